// ----- hw/rtl/sorted_table_binary_search_macros.svh -----
// Assertion helpers used by the top-level file to check its own logic.
// Each macro takes a label, the clock, the active low reset, two conditions
// and a message string.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

`define SBS_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

`define SBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`else

`define SBS_ASSERT_SAME(label, clk, rst_n, cond, prop, msg)

`define SBS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ----- hw/rtl/sbs_pkg.sv -----
package sbs_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic REG_COMPARE_SIGNED = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [9:0]  entry_index;
		logic [31:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic       found;
		logic [9:0] match_index;
	} rsp_t;

	typedef struct packed {
		logic [10:0] entries_in_use;
		logic        compare_signed;
	} cfg_t;

endpackage

// ----- hw/rtl/sbs_cfg_regs.sv -----
module sbs_cfg_regs
	import sbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	// Registers sit on word boundaries, so bit 2 picks the register.
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_ENTRIES_IN_USE: cfg_q.entries_in_use <= pwdata[10:0];
				REG_COMPARE_SIGNED: cfg_q.compare_signed <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ENTRIES_IN_USE: prdata = {21'b0, cfg_q.entries_in_use};
			REG_COMPARE_SIGNED: prdata = {31'b0, cfg_q.compare_signed};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/sbs_key_ram.sv -----
module sbs_key_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/sbs_search_seq.sv -----
module sbs_search_seq
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32,
	parameter int AW          = 10,
	parameter int CW          = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [KEY_WIDTH-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  logic [KEY_WIDTH-1:0] ram_rdata
);

	localparam int EW  = (AW > 10) ? AW : 10;
	localparam int KXW = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PROBE  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]           state_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [AW-1:0]        mid_q;
	logic                 res_found_q;
	logic [9:0]           res_index_q;

	logic                 accept;
	logic [EW-1:0]        index_ext;
	logic [KXW-1:0]       key_ext;
	logic [KEY_WIDTH-1:0] key_in;
	logic [31:0]          count_clip;
	logic [CW-1:0]        count_sat;
	logic [KEY_WIDTH-1:0] sign_flip;
	logic [KEY_WIDTH-1:0] probe_key;
	logic [KEY_WIDTH-1:0] probe_entry;
	logic                 key_lt;
	logic                 key_eq;
	logic [CW-1:0]        mid_ext;
	logic [CW-1:0]        lo_nx;
	logic [CW-1:0]        hi_nx;
	logic [CW:0]          span_sum;
	logic [AW-1:0]        mid_nx;
	logic                 more;
	logic [EW-1:0]        mid_wide;
	logic                 out_free;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign index_ext = EW'(cmd.entry_index);
	assign key_ext   = KXW'(cmd.key_value);
	assign key_in    = key_ext[KEY_WIDTH-1:0];

	assign count_clip = (32'(cfg.entries_in_use) > 32'(TABLE_DEPTH)) ?
		32'(TABLE_DEPTH) : 32'(cfg.entries_in_use);
	assign count_sat  = CW'(count_clip);

	// Flipping the sign bit turns two's complement order into unsigned order.
	assign sign_flip   = KEY_WIDTH'(cfg.compare_signed) << (KEY_WIDTH - 1);
	assign probe_key   = key_q ^ sign_flip;
	assign probe_entry = ram_rdata ^ sign_flip;
	assign key_lt      = probe_key < probe_entry;
	assign key_eq      = probe_key == probe_entry;

	assign mid_ext = CW'(mid_q);

	// The next interval and its midpoint are worked out in the same cycle as
	// the compare, so the next read goes out at once.
	always_comb begin
		if (state_q == ST_PROBE) begin
			lo_nx = key_lt ? lo_q : mid_ext + CW'(1);
			hi_nx = key_lt ? mid_ext : hi_q;
		end else begin
			lo_nx = '0;
			hi_nx = count_sat;
		end
	end

	assign span_sum  = {1'b0, lo_nx} + {1'b0, hi_nx};
	assign mid_nx    = span_sum[AW:1];
	assign more      = lo_nx < hi_nx;

	assign ram_re    = ((state_q == ST_IDLE) && accept && (cmd.operation == OP_SEARCH) && more)
		|| ((state_q == ST_PROBE) && !key_eq && more);
	assign ram_raddr = mid_nx;

	// Writes are taken only when no search is under way, so reads and writes
	// of the table never overlap.
	assign ram_we    = accept && (cmd.operation == OP_WRITE)
		&& (32'(cmd.entry_index) < 32'(TABLE_DEPTH));
	assign ram_waddr = index_ext[AW-1:0];
	assign ram_wdata = key_in;

	assign mid_wide  = EW'(mid_q);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.operation == OP_SEARCH)) begin
						state_q <= more ? ST_PROBE : ST_FINISH;
					end
				end
				ST_PROBE: begin
					if (key_eq || !more) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.operation == OP_SEARCH)) begin
					key_q       <= key_in;
					lo_q        <= lo_nx;
					hi_q        <= hi_nx;
					mid_q       <= mid_nx;
					res_found_q <= 1'b0;
					res_index_q <= '0;
				end
			end
			ST_PROBE: begin
				if (key_eq) begin
					res_found_q <= 1'b1;
					res_index_q <= mid_wide[9:0];
				end else begin
					lo_q  <= lo_nx;
					hi_q  <= hi_nx;
					mid_q <= mid_nx;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					rsp_q.found       <= res_found_q;
					rsp_q.match_index <= res_index_q;
				end
			end
			default: begin
				res_found_q <= 1'b0;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/sorted_table_binary_search.sv -----
// Write item: stored in the cycle it is accepted; the block is free again next cycle.
// Search item: the first read is issued when the item is accepted, then each probe is
// a table read with the compare and next midpoint on its data, then the result is
// loaded into the output register once the output is free.
// Reset clears the configuration registers and the sequencer; the key table is not
// cleared and every entry must be written before a search may read it.
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search
	import sbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	cfg_t                 cfg;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [KEY_WIDTH-1:0] ram_rdata;

	sbs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbs_key_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (KEY_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sbs_search_seq #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.AW          (AW),
		.CW          (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	`SBS_ASSERT_SAME(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re, "table read and write overlap")
	`SBS_ASSERT_SAME(a_write_from_item, clk, arst_n, ram_we, cmd_valid && !cmd_stall && (cmd.operation == OP_WRITE), "table write without a write item")
	`SBS_ASSERT_SAME(a_search_reads, clk, arst_n, cmd_valid && !cmd_stall && (cmd.operation == OP_SEARCH) && (cfg.entries_in_use != 11'd0), ram_re, "search item did not start a probe")
	`SBS_ASSERT_NEXT(a_busy_after_search, clk, arst_n, cmd_valid && !cmd_stall && (cmd.operation == OP_SEARCH), cmd_stall, "block took a new item during a search")

endmodule

// ----- tb/tb_sorted_table_binary_search.sv -----
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;
	import sbs_pkg::*;

	localparam int DEPTH = 1024;
	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

	typedef enum int {FILL_SORTED, FILL_RANDOM, FILL_KEEP} fill_mode_t;

	// Mirror of the key table and registers; predicts one result per search item.
	class table_mirror;
		logic [31:0] key_table [DEPTH];
		logic [10:0] entries_in_use;
		logic        compare_signed;
		rsp_t        pending_results [$];
		int          mismatches;

		function new();
			entries_in_use = '0;
			compare_signed = 1'b0;
			mismatches = 0;
		endfunction

		function void write_register(logic sel, logic [31:0] value);
			if (sel == REG_ENTRIES_IN_USE) begin
				entries_in_use = value[10:0];
			end else begin
				compare_signed = value[0];
			end
		endfunction

		function rsp_t search_result(logic [31:0] key);
			int          lo, hi, mid;
			logic [31:0] flip, a, b;
			rsp_t        r;
			r = '0;
			lo = 0;
			hi = (entries_in_use > DEPTH) ? DEPTH : int'(entries_in_use);
			// Flipping the sign bit turns signed order into unsigned order.
			flip = compare_signed ? SIGN_BIT : 32'h0;
			a = key ^ flip;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				b = key_table[mid] ^ flip;
				if (a < b) begin
					hi = mid;
				end else if (a > b) begin
					lo = mid + 1;
				end else begin
					r.found = 1'b1;
					r.match_index = mid[9:0];
					break;
				end
			end
			return r;
		endfunction

		function void accept_cmd(cmd_t c);
			if (c.operation == OP_WRITE) begin
				key_table[c.entry_index] = c.key_value;
			end else begin
				pending_results.push_back(search_result(c.key_value));
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				$error("result with no search waiting: found %0d match_index %0d",
					got.found, got.match_index);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, got.found);
				mismatches++;
			end
			if (got.match_index !== want.match_index) begin
				$error("match_index: expected %0d, actual %0d",
					want.match_index, got.match_index);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	table_mirror board;
	bit          idle_on = 1'b1;
	int          hold_left = 0;
	int          items_sent = 0;

	sorted_table_binary_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// Result side: random stalls, or a counted hold-off when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= idle_on && ($urandom_range(0, 99) < 21);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && board != null && rsp_valid && !rsp_stall) begin
			board.check_result(rsp);
		end
	end

	function automatic cmd_t make_item(logic op, logic [9:0] idx, logic [31:0] key);
		cmd_t c;
		c.operation = op;
		c.entry_index = idx;
		c.key_value = key;
		return c;
	endfunction

	task automatic send_item(input cmd_t c);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 21) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		board.accept_cmd(c);
		items_sent++;
	endtask

	task automatic write_entry(input int idx, input logic [31:0] key);
		send_item(make_item(OP_WRITE, idx[9:0], key));
	endtask

	task automatic search_for(input logic [31:0] key);
		send_item(make_item(OP_SEARCH, 10'($urandom), key));
	endtask

	// Stop offering items and let every outstanding search come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_register(input logic sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.write_register(sel, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int count, input logic signed_order, input fill_mode_t mode,
			input int searches);
		int              span, idx, pick;
		longint unsigned u, budget, step;
		logic [31:0]     key;
		drain();
		set_register(REG_ENTRIES_IN_USE, {21'($urandom), count[10:0]});
		set_register(REG_COMPARE_SIGNED, {31'($urandom), signed_order});
		span = (count > DEPTH) ? DEPTH : count;
		if (mode == FILL_SORTED) begin
			u = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom >> $urandom_range(2, 12));
			for (int i = 0; i < span; i++) begin
				if (i > 0) begin
					// Share the room left below the top among the remaining entries.
					budget = (64'hFFFF_FFFF - u) / longint'(span - i);
					if ($urandom_range(0, 3) == 0) begin
						step = $urandom_range(0, 1);
					end else begin
						step = longint'($urandom) % (budget + 1);
					end
					if (step > budget) step = budget;
					u += step;
				end
				write_entry(i, u[31:0] ^ (signed_order ? SIGN_BIT : 32'h0));
			end
		end else if (mode == FILL_RANDOM) begin
			for (int i = 0; i < span; i++) write_entry(i, $urandom);
		end
		for (int i = 0; i < searches; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				write_entry($urandom_range(0, DEPTH - 1), $urandom);
			end else begin
				key = $urandom;
				if (span > 0 && pick < 80) begin
					idx = $urandom_range(0, span - 1);
					key = board.key_table[idx];
					if (pick >= 60) key = (pick & 1) ? key + 1 : key - 1;
				end
				search_for(key);
			end
		end
	endtask

	initial begin
		int n_rand, k;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table straight out of reset.
		search_for(32'h0000_0000);
		search_for(32'hFFFF_FFFF);
		write_entry(DEPTH - 1, 32'hFFFF_FFFF);
		write_entry(0, 32'h0000_0000);
		write_entry(1, 32'h0000_0001);
		write_entry(2, 32'h7FFF_FFFF);
		write_entry(3, 32'h8000_0000);
		write_entry(4, 32'hFFFF_FFFF);
		drain();
		set_register(REG_ENTRIES_IN_USE, 32'd5);
		search_for(32'h0000_0000);
		search_for(32'h0000_0001);
		search_for(32'h7FFF_FFFF);
		search_for(32'h8000_0000);
		search_for(32'hFFFF_FFFF);
		search_for(32'h0000_0002);
		search_for(32'h8000_0001);
		// Same table under signed order is no longer sorted.
		drain();
		set_register(REG_COMPARE_SIGNED, 32'd1);
		search_for(32'hFFFF_FFFF);
		search_for(32'h8000_0000);
		search_for(32'h0000_0000);
		write_entry(0, 32'h8000_0000);
		write_entry(1, 32'hFFFF_FFFF);
		write_entry(2, 32'h0000_0000);
		write_entry(3, 32'h0000_0001);
		write_entry(4, 32'h7FFF_FFFF);
		search_for(32'h8000_0000);
		search_for(32'h7FFF_FFFF);

		run_phase(1, 1'b0, FILL_SORTED, 20);
		run_phase(2, 1'b1, FILL_SORTED, 20);
		run_phase(0, 1'b1, FILL_RANDOM, 10);

		k = 0;
		while (k < 4) begin
			n_rand = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8) : $urandom_range(9, 40);
			if (k == 1) begin
				// Hold results back long enough for the block to stall its input.
				hold_left = 400;
			end
			if (k == 2) idle_on = 1'b0;
			run_phase(n_rand, 1'($urandom), ($urandom_range(0, 5) == 0) ? FILL_RANDOM : FILL_SORTED,
				$urandom_range(20, 40));
			idle_on = 1'b1;
			k++;
		end

		// Count past the table end covers the whole table.
		run_phase(2047, 1'b1, FILL_SORTED, 40);
		// The same keys searched in the other order.
		run_phase(2047, 1'b0, FILL_KEEP, 30);

		drain();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("tb_sorted_table_binary_search passed");
		end else begin
			$display("tb_sorted_table_binary_search failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_sorted_table_binary_search failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_cfg_regs.sv
hw/rtl/sbs_key_ram.sv
hw/rtl/sbs_search_seq.sv
hw/rtl/sorted_table_binary_search.sv
tb/tb_sorted_table_binary_search.sv
